[src/hrpf_pkg.sv]
package hrpf_pkg;
    localparam int MedianDepthDefault = 5;
    localparam int NumRegs = 8;
    localparam int AddrWidth = 5;

    localparam logic [2:0] RegEnabled   = 3'd0;
    localparam logic [2:0] RegInterval  = 3'd1;
    localparam logic [2:0] RegWindow    = 3'd2;
    localparam logic [2:0] RegMinSamp   = 3'd3;
    localparam logic [2:0] RegStepLimit = 3'd4;
    localparam logic [2:0] RegLostLimit = 3'd5;
    localparam logic [2:0] RegValidMin  = 3'd6;
    localparam logic [2:0] RegValidMax  = 3'd7;
endpackage

[src/heart_rate_post_filter.sv]
// Heart-rate post filter. Each request on the slave stream is one handler call
// (tdata: tick[31:0], raw_invalid[32], rate_estimate[48:33]); each yields one
// result (tdata: shown_rate[7:0], rate_present[8]). Calls that are skipped, invalid
// or leave the averaging window open, or close it with too few samples, offer their
// result in the cycle after the accept cycle. A call that closes the window with
// enough samples runs a restoring divider, one quotient bit per cycle, loads the
// ring, then sorts it as an exchange sort over all pairs with one shared comparator,
// one compare/swap per cycle, and applies the step limit. The result is held until
// the master side takes it. The block is not ready during that work or while the
// result is offered. Writing the enable register clears all kept state.
module heart_rate_post_filter #(
    parameter int MEDIAN_DEPTH = hrpf_pkg::MedianDepthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [hrpf_pkg::AddrWidth-1:0] i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [55:0]                   i_s_tdata,  // tick, raw_invalid, rate_estimate
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [15:0]                   o_m_tdata   // shown_rate, rate_present
);
    import hrpf_pkg::*;

    localparam int IW = $clog2(MEDIAN_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MED, S_SORT, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    logic        r_enabled;
    logic [15:0] r_interval, r_window, r_minsamp;
    logic [7:0]  r_step, r_lost, r_vmin, r_vmax;

    logic [7:0]  r_last_rate, r_invalid_run;
    logic [31:0] r_last_time, r_win_start;
    logic [23:0] r_win_sum;
    logic [15:0] r_win_cnt;
    logic [7:0]  r_win_low, r_win_high;
    logic [7:0]  r_ring [MEDIAN_DEPTH];
    logic [7:0]  r_sort [MEDIAN_DEPTH];
    logic [IW-1:0] r_fill, r_pos, r_i, r_j;

    logic [23:0] r_num, r_quo;
    logic [24:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_bit;
    logic [7:0]  r_hr;

    // input decode
    logic [31:0] in_now;
    logic        in_bad;
    logic [15:0] in_est;
    assign in_now = i_s_tdata[31:0];
    assign in_bad = i_s_tdata[32];
    assign in_est = i_s_tdata[48:33];

    logic cfg_wr;
    logic [2:0] cfg_idx;
    assign cfg_wr  = i_psel && i_penable && i_pwrite;
    assign cfg_idx = i_paddr[4:2];
    assign o_pready = 1'b1;

    always_comb begin
        case (cfg_idx)
            RegEnabled:   o_prdata = {31'd0, r_enabled};
            RegInterval:  o_prdata = {16'd0, r_interval};
            RegWindow:    o_prdata = {16'd0, r_window};
            RegMinSamp:   o_prdata = {16'd0, r_minsamp};
            RegStepLimit: o_prdata = {24'd0, r_step};
            RegLostLimit: o_prdata = {24'd0, r_lost};
            RegValidMin:  o_prdata = {24'd0, r_vmin};
            RegValidMax:  o_prdata = {24'd0, r_vmax};
            default:      o_prdata = 32'd0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {7'd0, (r_last_rate != 8'd0), r_last_rate};

    // mean arithmetic on the window after adding the current sample
    logic [15:0] cnt_a;
    logic [23:0] sum_a;
    logic [7:0]  low_a, high_a, est8;
    logic [31:0] start_a;
    assign est8 = in_est[7:0];

    always_comb begin
        cnt_a = r_win_cnt;
        sum_a = r_win_sum;
        low_a = r_win_low;
        high_a = r_win_high;
        start_a = r_win_start;
        // full window ignores further samples until it closes
        if (r_win_cnt != 16'hFFFF) begin
            if (r_win_cnt == 16'd0) begin
                start_a = in_now; low_a = est8; high_a = est8;
            end else begin
                if (est8 < r_win_low) low_a = est8;
                if (est8 > r_win_high) high_a = est8;
            end
            sum_a = r_win_sum + {16'd0, est8};
            cnt_a = r_win_cnt + 16'd1;
        end
    end

    // divider step
    logic [24:0] rem_sh;
    assign rem_sh = {r_rem[23:0], r_num[23]};

    // sort compare
    logic [IW-1:0] n_fill_c;
    logic swap;
    assign swap = r_sort[r_i] > r_sort[r_j];

    logic [8:0] med_sum;
    logic [IW-1:0] half;
    assign half = r_fill >> 1;
    assign med_sum = {1'b0, r_sort[half - IW'(1)]} + {1'b0, r_sort[half]} + 9'd1;

    logic [8:0] up_lim;
    logic [7:0] lim_hr;
    always_comb begin
        up_lim = {1'b0, r_last_rate} + {1'b0, r_step};
        lim_hr = r_hr;
        if (r_last_rate != 8'd0) begin
            if (r_hr > r_last_rate) begin
                if (r_hr - r_last_rate > r_step) lim_hr = up_lim[7:0];
            end else if (r_last_rate - r_hr > r_step) begin
                lim_hr = r_last_rate - r_step;
            end
        end
    end
    assign n_fill_c = (r_fill < IW'(MEDIAN_DEPTH)) ? r_fill + IW'(1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_enabled <= 1'b0; r_interval <= 16'd40; r_window <= 16'd5000;
            r_minsamp <= 16'd3; r_step <= 8'd10; r_lost <= 8'd5;
            r_vmin <= 8'd40; r_vmax <= 8'd200;
            r_last_rate <= '0; r_invalid_run <= '0; r_last_time <= '0;
            r_win_start <= '0; r_win_sum <= '0; r_win_cnt <= '0;
            r_win_low <= '0; r_win_high <= '0;
            r_fill <= '0; r_pos <= '0;
            for (int k = 0; k < MEDIAN_DEPTH; k++) r_ring[k] <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    RegEnabled: begin
                        r_enabled <= i_pwdata[0];
                        r_last_rate <= '0; r_invalid_run <= '0; r_last_time <= '0;
                        r_win_start <= '0; r_win_sum <= '0; r_win_cnt <= '0;
                        r_win_low <= '0; r_win_high <= '0;
                        r_fill <= '0; r_pos <= '0;
                        for (int k = 0; k < MEDIAN_DEPTH; k++) r_ring[k] <= '0;
                    end
                    RegInterval:  r_interval <= i_pwdata[15:0];
                    RegWindow:    r_window <= i_pwdata[15:0];
                    RegMinSamp:   r_minsamp <= i_pwdata[15:0];
                    RegStepLimit: r_step <= i_pwdata[7:0];
                    RegLostLimit: r_lost <= i_pwdata[7:0];
                    RegValidMin:  r_vmin <= i_pwdata[7:0];
                    RegValidMax:  r_vmax <= i_pwdata[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_OUT;
                        if (r_enabled && !(r_last_time != 32'd0 &&
                                (in_now - r_last_time) < {16'd0, r_interval})) begin
                            r_last_time <= in_now;
                            if (in_bad || (!(in_est >= {8'd0, r_vmin} &&
                                    in_est <= {8'd0, r_vmax}) && r_last_rate != 8'd0)) begin
                                if (r_invalid_run != 8'hFF && r_invalid_run + 8'd1 >= r_lost ||
                                    r_invalid_run == 8'hFF && r_invalid_run >= r_lost) begin
                                    r_last_rate <= '0;
                                    r_win_start <= '0; r_win_sum <= '0; r_win_cnt <= '0;
                                    r_win_low <= '0; r_win_high <= '0;
                                    r_fill <= '0; r_pos <= '0;
                                    for (int k = 0; k < MEDIAN_DEPTH; k++) r_ring[k] <= '0;
                                end
                                if (r_invalid_run != 8'hFF)
                                    r_invalid_run <= r_invalid_run + 8'd1;
                            end else if (in_est >= {8'd0, r_vmin} &&
                                         in_est <= {8'd0, r_vmax}) begin
                                r_invalid_run <= '0;
                                r_win_start <= start_a; r_win_sum <= sum_a;
                                r_win_cnt <= cnt_a; r_win_low <= low_a; r_win_high <= high_a;
                                if ((in_now - start_a) >= {16'd0, r_window}) begin
                                    if (cnt_a < r_minsamp) begin
                                        r_win_start <= '0; r_win_sum <= '0; r_win_cnt <= '0;
                                        r_win_low <= '0; r_win_high <= '0;
                                    end else begin
                                        r_win_start <= '0; r_win_sum <= '0; r_win_cnt <= '0;
                                        r_win_low <= '0; r_win_high <= '0;
                                        if (cnt_a > 16'd2) begin
                                            r_num <= sum_a - {16'd0, low_a} - {16'd0, high_a}
                                                     + {8'd0, (cnt_a - 16'd2) >> 1};
                                            r_den <= cnt_a - 16'd2;
                                        end else begin
                                            r_num <= sum_a + {8'd0, cnt_a >> 1};
                                            r_den <= cnt_a;
                                        end
                                        r_rem <= '0; r_quo <= '0; r_bit <= 5'd0;
                                        r_state <= S_DIV;
                                    end
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {9'd0, r_den}) begin
                        r_rem <= rem_sh - {9'd0, r_den};
                        r_quo <= {r_quo[22:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[22:0], 1'b0};
                    end
                    r_num <= {r_num[22:0], 1'b0};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd23) r_state <= S_MED;
                end
                S_MED: begin
                    r_ring[r_pos] <= r_quo[7:0];
                    r_pos <= (r_pos == IW'(MEDIAN_DEPTH - 1)) ? '0 : r_pos + IW'(1);
                    r_fill <= n_fill_c;
                    for (int k = 0; k < MEDIAN_DEPTH; k++)
                        r_sort[k] <= (IW'(k) == r_pos) ? r_quo[7:0] : r_ring[k];
                    r_i <= '0; r_j <= IW'(1);
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (r_i + IW'(1) >= r_fill) begin
                        r_hr <= r_fill[0] ? r_sort[half] : med_sum[8:1];
                        r_state <= S_FIN;
                    end else begin
                        if (swap) begin
                            r_sort[r_i] <= r_sort[r_j];
                            r_sort[r_j] <= r_sort[r_i];
                        end
                        if (r_j + IW'(1) >= r_fill) begin
                            r_i <= r_i + IW'(1);
                            r_j <= r_i + IW'(2);
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                S_FIN: begin
                    r_last_rate <= lim_hr;
                    r_invalid_run <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^{i_s_tdata[55:49], i_paddr[1:0]};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid) else $error("ready while result pending");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == 5'd23) |=> r_state == S_MED)
        else $error("divider did not finish");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IW'(MEDIAN_DEPTH)) else $error("median fill overflow");
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8] == (o_m_tdata[7:0] != 8'd0)))
        else $error("present flag mismatch");
endmodule
